FILE: src/psa_pkg.sv
`timescale 1ns / 1ps
// psa_pkg: shared types and constants for the saturation adjust pipeline.
// No dependencies.
package psa_pkg;

    localparam int PIX_W  = 8;
    localparam int STR_W  = 10;
    localparam int REM_W  = 19;
    localparam int DV_W   = 10;
    localparam int Q_W    = 9;
    localparam int NCELL  = Q_W;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic                   valid;
        logic                   gray;
        logic [2:0][PIX_W-1:0]  pix;
        logic [2:0]             neg;
        logic [2:0][REM_W-1:0]  rem;
        logic [DV_W-1:0]        dv;
        logic [2:0][Q_W-1:0]    q;
    } t_cell;

endpackage

FILE: src/pixel_saturation_adjust_core.sv
`timescale 1ns / 1ps
// pixel_saturation_adjust_core: top level, strength register, divide chain, output.
// Depends on psa_pkg, psa_front, psa_cell.
//
// Usage:
//   Pixels enter on i_in_valid / o_in_ready with i_red_in, i_green_in, i_blue_in;
//   adjusted pixels leave on o_out_valid / i_out_ready. One beat per cycle is
//   taken and delivered when the receiver keeps up.
//   From input beat to output valid a pixel passes three front stages
//   (statistics, products, numerator), nine divide cells each resolving one
//   quotient bit (the top bit flags saturation), then the output register.
//   Throughput is one pixel per clock when not stalled; the divide spans the cell row.
//   When the receiver stalls the whole pipeline holds and o_in_ready drops
//   until the output register is emptied.
//   Strength is written via i_cfg_wr_en / i_cfg_wr_data, taken at the next
//   edge; write it only when the pipeline is empty.
//   Synchronous reset clears all valid flags and sets strength to zero.
module pixel_saturation_adjust_core
    import psa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [STR_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [PIX_W-1:0] i_red_in,
    input  logic [PIX_W-1:0] i_green_in,
    input  logic [PIX_W-1:0] i_blue_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [PIX_W-1:0] o_red_out,
    output logic [PIX_W-1:0] o_green_out,
    output logic [PIX_W-1:0] o_blue_out
);

    logic [STR_W-1:0]      r_strength;
    logic                  en;
    logic [2:0][PIX_W-1:0] pix_in;
    t_cell                 w_chain [NCELL+1];
    t_cell                 w_last;
    logic [2:0][PIX_W-1:0] n_pix, r_pix;
    logic                  r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength <= '0;
        end else if (i_cfg_wr_en) begin
            r_strength <= i_cfg_wr_data;
        end
    end

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;
    assign pix_in     = {i_blue_in, i_green_in, i_red_in};

    psa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_in_valid),
        .i_pix      (pix_in),
        .i_strength (r_strength),
        .o_cell     (w_chain[0])
    );

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        psa_cell #(.SHIFT(NCELL - 1 - g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    assign w_last = w_chain[NCELL];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (w_last.gray) begin
                n_pix[k] = w_last.pix[k];
            end else if (w_last.neg[k]) begin
                n_pix[k] = '0;
            end else if (w_last.q[k][Q_W-1]) begin
                n_pix[k] = '1;
            end else begin
                n_pix[k] = w_last.q[k][PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_last.valid;
        end
        if (en) begin
            r_pix <= n_pix;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_red_out   = r_pix[0];
    assign o_green_out = r_pix[1];
    assign o_blue_out  = r_pix[2];

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> r_strength == $past(i_cfg_wr_data))
        else $error("strength register missed a write");

    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> $stable(w_last))
        else $error("divide chain moved during stall");

    a_neg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && w_last.valid && !w_last.gray && w_last.neg == 3'b111)
        |=> (o_red_out == '0 && o_green_out == '0 && o_blue_out == '0))
        else $error("negative numerator not clamped to zero");

endmodule

FILE: src/psa_front.sv
`timescale 1ns / 1ps
// psa_front: channel statistics, coefficient select and numerator build.
// Depends on psa_pkg.
module psa_front
    import psa_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [2:0][PIX_W-1:0]   i_pix,
    input  logic [STR_W-1:0]        i_strength,
    output t_cell                   o_cell
);

    // stage 1
    logic [7:0]  mx, mn, d, den;
    logic [8:0]  sm;
    logic [16:0] sden;
    logic [17:0] lhs, rhs;
    logic        mode_a, s_neg;
    logic [9:0]  k1, dv;
    logic signed [9:0] k2;

    logic              r1_valid, r1_gray, r1_sneg;
    logic [2:0][7:0]   r1_pix;
    logic [8:0]        r1_sm;
    logic [9:0]        r1_k1, r1_dv;
    logic signed [9:0] r1_k2;

    always_comb begin
        mx = i_pix[0];
        mn = i_pix[0];
        for (int k = 1; k < 3; k++) begin
            if (i_pix[k] > mx) mx = i_pix[k];
            if (i_pix[k] < mn) mn = i_pix[k];
        end
        d    = mx - mn;
        sm   = {1'b0, mx} + {1'b0, mn};
        den  = (sm < 9'd255) ? sm[7:0] : 8'(9'd510 - sm);
        s_neg = i_strength[STR_W-1];
        sden = 17'(i_strength[8:0]) * 17'(den);
        lhs  = 18'(sden) + {2'b0, d, 8'b0};
        rhs  = {2'b0, den, 8'b0};
        mode_a = lhs >= rhs;
        if (s_neg) begin
            k1 = '0;
            k2 = $signed(i_strength) + 10'sd256;
            dv = 10'd512;
        end else if (mode_a) begin
            k1 = {1'b0, d, 1'b0};
            k2 = $signed({2'b0, 8'(den - d)});
            dv = {1'b0, d, 1'b0};
        end else begin
            k1 = 10'd512 - {1'b0, i_strength[7:0], 1'b0};
            k2 = $signed({2'b0, i_strength[7:0]});
            dv = k1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_gray <= (d == 8'd0);
            r1_sneg <= s_neg;
            r1_pix  <= i_pix;
            r1_sm   <= sm;
            r1_k1   <= k1;
            r1_k2   <= k2;
            r1_dv   <= dv;
        end
    end

    // stage 2: products
    logic signed [10:0] off2 [3];
    logic [2:0][17:0]   base;
    logic signed [20:0] prod [3];

    logic              r2_valid, r2_gray;
    logic [2:0][7:0]   r2_pix;
    logic [9:0]        r2_dv;
    logic [2:0][17:0]  r2_base;
    logic signed [20:0] r2_prod [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            off2[k] = $signed({2'b0, r1_pix[k], 1'b0}) - $signed({2'b0, r1_sm});
            base[k] = r1_sneg ? {1'b0, r1_sm, 8'b0} : 18'(r1_k1) * 18'(r1_pix[k]);
            prod[k] = off2[k] * r1_k2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_gray <= r1_gray;
            r2_pix  <= r1_pix;
            r2_dv   <= r1_dv;
            r2_base <= base;
            for (int k = 0; k < 3; k++) r2_prod[k] <= prod[k];
        end
    end

    // stage 3: numerator, sign split
    logic signed [21:0] num [3];
    t_cell              n_cell, r_cell;

    always_comb begin
        n_cell       = '0;
        n_cell.valid = r2_valid;
        n_cell.gray  = r2_gray;
        n_cell.pix   = r2_pix;
        n_cell.dv    = r2_dv;
        for (int k = 0; k < 3; k++) begin
            num[k] = $signed({4'b0, r2_base[k]}) + 22'(r2_prod[k]);
            n_cell.neg[k] = num[k][21];
            n_cell.rem[k] = num[k][21] ? '0 : num[k][REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

FILE: src/psa_cell.sv
`timescale 1ns / 1ps
// psa_cell: one quotient bit of the restoring divide, for all three channels.
// Depends on psa_pkg.
module psa_cell
    import psa_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_cell i_cell,
    output t_cell o_cell
);

    logic [REM_W-1:0] sub;
    t_cell            n_cell, r_cell;

    always_comb begin
        n_cell = i_cell;
        sub    = REM_W'(i_cell.dv) << SHIFT;
        for (int k = 0; k < 3; k++) begin
            if (i_cell.rem[k] >= sub) begin
                n_cell.rem[k] = i_cell.rem[k] - sub;
                n_cell.q[k]   = {i_cell.q[k][Q_W-2:0], 1'b1};
            end else begin
                n_cell.q[k]   = {i_cell.q[k][Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule
